### sv/mtes_pkg.sv
// Shared constants, codes and handshake structs for the MIDI track event serializer.
package mtes_pkg;

	localparam int TRACK_COUNT = 17;
	localparam int TRK_W       = 5;
	localparam int TICK_W      = 32;
	localparam int DELTA_W     = 28;
	localparam int US_W        = 24;
	localparam int DIV_W       = 34;
	localparam int IDX_W       = 4;
	localparam int S_DATA_W    = 112;
	localparam int S_USER_W    = 3;
	localparam int M_DATA_W    = 8;
	localparam int M_USER_W    = TRK_W;

	// 60e6 us per minute scaled by the 8 fraction bits of the tempo
	localparam logic [DIV_W-1:0]   DIV_NUM  = 34'd15360000000;
	localparam logic [US_W-1:0]    US_MAX   = 24'hFFFFFF;
	localparam logic [DELTA_W-1:0] VLQ_LIM3 = 28'h1FFFFF;
	localparam logic [DELTA_W-1:0] VLQ_LIM2 = 28'h3FFF;
	localparam logic [DELTA_W-1:0] VLQ_LIM1 = 28'h7F;

	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_CTRL     = 8'hB0;
	localparam logic [7:0] ST_PROGRAM  = 8'hC0;
	localparam logic [7:0] ST_META     = 8'hFF;
	localparam logic [7:0] CC_BANK_MSB = 8'h00;
	localparam logic [7:0] CC_BANK_LSB = 8'h20;
	localparam logic [7:0] META_TSIG   = 8'h58;
	localparam logic [7:0] META_TEMPO  = 8'h51;
	localparam logic [7:0] META_EOT    = 8'h2F;
	localparam logic [7:0] TSIG_LEN    = 8'h04;
	localparam logic [7:0] TEMPO_LEN   = 8'h03;
	localparam logic [7:0] EOT_LEN     = 8'h00;
	localparam logic [7:0] TSIG_CLOCKS = 8'h18;
	localparam logic [7:0] TSIG_32ND   = 8'h08;
	localparam logic [7:0] ZERO_BYTE   = 8'h00;

	typedef enum logic [2:0] {
		MODE_NOTE_ON   = 3'd0,
		MODE_NOTE_OFF  = 3'd1,
		MODE_PROGRAM   = 3'd2,
		MODE_TIME_SIG  = 3'd3,
		MODE_TEMPO     = 3'd4,
		MODE_TRACK_END = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_DELTA,
		S_BODY
	} state_t;

	typedef struct packed {
		logic             load;
		logic             check;
		logic             emit;
		logic             body;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic             ok;
		logic             tempo;
		logic [1:0]       dlast;
		logic [IDX_W-1:0] blast;
		logic             div_done;
		logic             out_free;
	} sts_t;

endpackage

### sv/midi_track_event_serializer_unit.sv
// An accepted item is checked, a tempo item then waits for the bit-serial divider (34 steps),
// and the first byte is then registered at the output. Throughput: one byte per cycle while
// the output is taken; a new item is accepted only after the last byte of the previous one.
// Dropped items (bad track, empty track end, unused mode) go back to idle after the check.
// Reset (arst_n low) clears all last ticks and track data flags and empties the output.
module midi_track_event_serializer_unit
	import mtes_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// tick[31:0] channel[36:32] note[43:37] velocity[50:44] bank_msb[57:51]
	// bank_lsb[64:58] program_req[71:65] beats[79:72] beat_unit[87:80] tempo_q8[111:88]
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// mode[2:0]
	input  logic [S_USER_W-1:0] s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// byte_value[7:0]
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// track[4:0]
	output logic [M_USER_W-1:0] m_axis_tuser,
	output logic                m_axis_tlast
);

	cmd_t cmd;
	sts_t sts;

	mtes_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	mtes_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### sv/mtes_div.sv
// Bit-serial restoring divider: constant dividend over the tempo, saturated to 24 bits.
module mtes_div
	import mtes_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [US_W-1:0] den,
	output logic            done,
	output logic [US_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [US_W-1:0]  den_q;
	logic [US_W-1:0]  rem_q;
	logic [DIV_W-1:0] nq_q;
	logic [US_W:0]    trial;
	logic             ge;
	logic [US_W:0]    diff;

	// dividend bits shift out at the top while quotient bits shift in below
	assign trial = {rem_q, nq_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			nq_q  <= DIV_NUM;
		end else if (busy_q) begin
			rem_q <= ge ? diff[US_W-1:0] : trial[US_W-1:0];
			nq_q  <= {nq_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = ((den_q == '0) || (|nq_q[DIV_W-1:US_W])) ? US_MAX : nq_q[US_W-1:0];

endmodule

### sv/mtes_dp.sv
// Datapath: event registers, per-track tick state, byte selection and output register.
module mtes_dp
	import mtes_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	input  logic [S_USER_W-1:0] s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,
	output logic [M_USER_W-1:0] m_axis_tuser,
	output logic                m_axis_tlast
);

	logic [2:0]        mode_q;
	logic [TICK_W-1:0] tick_q;
	logic [TRK_W-1:0]  chan_q;
	logic [6:0]        note_q;
	logic [6:0]        vel_q;
	logic [6:0]        msb_q;
	logic [6:0]        lsb_q;
	logic [6:0]        prog_q;
	logic [7:0]        beats_q;
	logic [7:0]        unit_q;
	logic [US_W-1:0]   tempo_q;
	logic [DELTA_W-1:0] d_q;

	logic [TICK_W-1:0] last_tick_q [TRACK_COUNT];
	logic              has_data_q  [TRACK_COUNT];

	logic                out_valid_q;
	logic [M_DATA_W-1:0] out_byte_q;
	logic [M_USER_W-1:0] out_trk_q;
	logic                out_last_q;

	logic               chan_ok;
	logic               meta_ev;
	logic [TRK_W-1:0]   trk;
	logic               ok;
	logic [TICK_W-1:0]  delta_full;
	logic [DELTA_W-1:0] d_n;
	logic [TRK_W-1:0]   chan_m1;
	logic [3:0]         nib;
	logic [1:0]         dlast;
	logic [IDX_W-1:0]   blast;
	logic [1:0]         k;
	logic [7:0]         dbyte;
	logic [7:0]         bbyte;
	logic [2:0]         lg;
	logic [US_W-1:0]    us;
	logic               div_done;
	logic               div_start;

	function automatic logic [2:0] floor_log2(input logic [7:0] v);
		logic [2:0] r;
		r = '0;
		for (int i = 1; i < 8; i++) begin
			if (v[i]) r = 3'(i);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= s_axis_tuser;
			tick_q  <= s_axis_tdata[31:0];
			chan_q  <= s_axis_tdata[36:32];
			note_q  <= s_axis_tdata[43:37];
			vel_q   <= s_axis_tdata[50:44];
			msb_q   <= s_axis_tdata[57:51];
			lsb_q   <= s_axis_tdata[64:58];
			prog_q  <= s_axis_tdata[71:65];
			beats_q <= s_axis_tdata[79:72];
			unit_q  <= s_axis_tdata[87:80];
			tempo_q <= s_axis_tdata[111:88];
		end
		if (cmd.check && ok) begin
			d_q <= d_n;
		end
	end

	assign chan_ok = chan_q < TRK_W'(TRACK_COUNT);
	assign meta_ev = (mode_q == MODE_TIME_SIG) || (mode_q == MODE_TEMPO);
	assign trk     = meta_ev ? '0 : chan_q;

	always_comb begin
		case (mode_q)
			MODE_NOTE_ON, MODE_NOTE_OFF, MODE_PROGRAM: ok = chan_ok;
			MODE_TIME_SIG, MODE_TEMPO:                 ok = 1'b1;
			MODE_TRACK_END:                            ok = chan_ok && has_data_q[chan_q];
			default:                                   ok = 1'b0;
		endcase
	end

	// track end leaves the last tick as it is and forces its delta to zero
	assign delta_full = tick_q - last_tick_q[trk];
	assign d_n = (mode_q == MODE_TRACK_END) ? '0 : delta_full[DELTA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACK_COUNT; i++) begin
				last_tick_q[i] <= '0;
				has_data_q[i]  <= 1'b0;
			end
		end else if (cmd.check && ok && (mode_q != MODE_TRACK_END)) begin
			last_tick_q[trk] <= tick_q;
			has_data_q[trk]  <= 1'b1;
		end
	end

	assign div_start = cmd.check && ok && (mode_q == MODE_TEMPO);

	mtes_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (tempo_q),
		.done   (div_done),
		.quot   (us)
	);

	always_comb begin
		if (d_q > VLQ_LIM3)      dlast = 2'd3;
		else if (d_q > VLQ_LIM2) dlast = 2'd2;
		else if (d_q > VLQ_LIM1) dlast = 2'd1;
		else                     dlast = 2'd0;
	end

	always_comb begin
		case (mode_q)
			MODE_PROGRAM:  blast = IDX_W'(9);
			MODE_TIME_SIG: blast = IDX_W'(6);
			MODE_TEMPO:    blast = IDX_W'(5);
			default:       blast = IDX_W'(2);
		endcase
	end

	// delta bytes go out most significant group first
	assign k = dlast - cmd.idx[1:0];

	always_comb begin
		case (k)
			2'd0:    dbyte = {1'b0, d_q[6:0]};
			2'd1:    dbyte = {1'b1, d_q[13:7]};
			2'd2:    dbyte = {1'b1, d_q[20:14]};
			default: dbyte = {1'b1, d_q[27:21]};
		endcase
	end

	assign chan_m1 = chan_q - TRK_W'(1);
	assign nib     = chan_m1[3:0];
	assign lg      = floor_log2(unit_q);

	always_comb begin
		bbyte = ZERO_BYTE;
		case (mode_q)
			MODE_NOTE_ON, MODE_NOTE_OFF: begin
				case (cmd.idx)
					IDX_W'(0): bbyte = ((mode_q == MODE_NOTE_ON) ? ST_NOTE_ON : ST_NOTE_OFF)
						| {4'h0, nib};
					IDX_W'(1): bbyte = {1'b0, note_q};
					default:   bbyte = (mode_q == MODE_NOTE_ON) ? {1'b0, vel_q} : ZERO_BYTE;
				endcase
			end
			MODE_PROGRAM: begin
				// the zero bytes between messages are the inner zero deltas
				case (cmd.idx)
					IDX_W'(0), IDX_W'(4): bbyte = ST_CTRL | {4'h0, nib};
					IDX_W'(1):            bbyte = CC_BANK_MSB;
					IDX_W'(2):            bbyte = {1'b0, msb_q};
					IDX_W'(5):            bbyte = CC_BANK_LSB;
					IDX_W'(6):            bbyte = {1'b0, lsb_q};
					IDX_W'(8):            bbyte = ST_PROGRAM | {4'h0, nib};
					IDX_W'(9):            bbyte = {1'b0, prog_q};
					default:              bbyte = ZERO_BYTE;
				endcase
			end
			MODE_TIME_SIG: begin
				case (cmd.idx)
					IDX_W'(0): bbyte = ST_META;
					IDX_W'(1): bbyte = META_TSIG;
					IDX_W'(2): bbyte = TSIG_LEN;
					IDX_W'(3): bbyte = beats_q;
					IDX_W'(4): bbyte = {5'b0, lg};
					IDX_W'(5): bbyte = TSIG_CLOCKS;
					default:   bbyte = TSIG_32ND;
				endcase
			end
			MODE_TEMPO: begin
				case (cmd.idx)
					IDX_W'(0): bbyte = ST_META;
					IDX_W'(1): bbyte = META_TEMPO;
					IDX_W'(2): bbyte = TEMPO_LEN;
					IDX_W'(3): bbyte = us[23:16];
					IDX_W'(4): bbyte = us[15:8];
					default:   bbyte = us[7:0];
				endcase
			end
			default: begin
				case (cmd.idx)
					IDX_W'(0): bbyte = ST_META;
					IDX_W'(1): bbyte = META_EOT;
					default:   bbyte = EOT_LEN;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= cmd.body ? bbyte : dbyte;
			out_trk_q  <= trk;
			out_last_q <= cmd.body && (cmd.idx == blast);
		end
	end

	assign sts.ok       = ok;
	assign sts.tempo    = mode_q == MODE_TEMPO;
	assign sts.dlast    = dlast;
	assign sts.blast    = blast;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_trk_q;
	assign m_axis_tlast  = out_last_q;

endmodule

### sv/mtes_ctrl.sv
// Controller: sequences accept, check, tempo division, delta bytes and body bytes.
module mtes_ctrl
	import mtes_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] cnt_q;
	logic             delta_end;
	logic             body_end;

	assign delta_end = sts.out_free && (cnt_q == {{(IDX_W-2){1'b0}}, sts.dlast});
	assign body_end  = sts.out_free && (cnt_q == sts.blast);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.ok)       state_d = S_IDLE;
				else if (sts.tempo) state_d = S_DIV;
				else               state_d = S_DELTA;
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_DELTA;
			end
			S_DELTA: begin
				if (delta_end) state_d = S_BODY;
			end
			S_BODY: begin
				if (body_end) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = state_q == S_IDLE;
		cmd.load      = s_axis_tvalid && (state_q == S_IDLE);
		cmd.check     = state_q == S_CHECK;
		cmd.emit      = ((state_q == S_DELTA) || (state_q == S_BODY)) && sts.out_free;
		cmd.body      = state_q == S_BODY;
		cmd.idx       = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			// restart the byte count at each phase change
			if ((state_q == S_DELTA && delta_end) || (state_q != S_DELTA && state_q != S_BODY))
				cnt_q <= '0;
			else if (cmd.emit)
				cnt_q <= cnt_q + IDX_W'(1);
		end
	end

endmodule

### sv/mtes_checker.sv
// Port-level checks for the serializer, bound to the top level.
module mtes_checker
	import mtes_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [M_DATA_W-1:0] m_axis_tdata,
	input logic [M_USER_W-1:0] m_axis_tuser,
	input logic                m_axis_tlast
);

	// a held byte keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("output item changed while stalled");

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while previous item in progress");

	// bytes of one event follow without a gap and stay on one track
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |=>
			m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser)))
		else $error("event byte stream broken or track changed mid event");

	a_track_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser < M_USER_W'(TRACK_COUNT))
		else $error("output track out of range");

endmodule

bind midi_track_event_serializer_unit mtes_checker u_mtes_checker (.*);

### sim/midi_track_event_serializer_unit_test.sv
// Self-checking testbench for the MIDI track event serializer: event stimulus, byte scoreboard.
`timescale 1ns / 1ps

module midi_track_event_serializer_unit_test;
	import mtes_pkg::*;

	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLDOFF_LEN   = 400;
	localparam int PHASE_EVENTS  = 87;
	localparam int TAIL_CYCLES   = 60;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		logic [2:0]  mode;
		logic [31:0] tick;
		logic [4:0]  channel;
		logic [6:0]  note;
		logic [6:0]  velocity;
		logic [6:0]  bank_msb;
		logic [6:0]  bank_lsb;
		logic [6:0]  program_req;
		logic [7:0]  beats;
		logic [7:0]  beat_unit;
		logic [23:0] tempo_q8;
	} midi_event_t;

	typedef struct packed {
		logic [4:0] track;
		logic [7:0] byte_value;
		logic       last_byte;
	} midi_byte_t;

	// Predicts the serialized bytes per event and checks them in order.
	class track_byte_scoreboard;
		midi_byte_t  expected_bytes[$];
		logic [31:0] last_tick [TRACK_COUNT];
		bit          has_data [TRACK_COUNT];
		int          errors;
		int          events_noted;
		int          events_dropped;
		int          bytes_checked;

		function new();
			foreach (last_tick[i]) begin
				last_tick[i] = '0;
				has_data[i]  = 1'b0;
			end
			errors         = 0;
			events_noted   = 0;
			events_dropped = 0;
			bytes_checked  = 0;
		endfunction

		function void push_byte(logic [4:0] trk, logic [7:0] val);
			expected_bytes.push_back({trk, val, 1'b0});
		endfunction

		// Variable-length delta, most significant 7-bit group first.
		function void push_delta(logic [4:0] trk, logic [31:0] tick);
			logic [31:0]        diff;
			logic [DELTA_W-1:0] d;
			diff = tick - last_tick[trk];
			d    = diff[DELTA_W-1:0];
			last_tick[trk] = tick;
			has_data[trk]  = 1'b1;
			if (d > VLQ_LIM3) push_byte(trk, {1'b1, d[27:21]});
			if (d > VLQ_LIM2) push_byte(trk, {1'b1, d[20:14]});
			if (d > VLQ_LIM1) push_byte(trk, {1'b1, d[13:7]});
			push_byte(trk, {1'b0, d[6:0]});
		endfunction

		function int note_event(midi_event_t ev);
			int          first;
			bit          dropped;
			logic [4:0]  trk;
			logic [7:0]  nib;
			logic [7:0]  lg;
			logic [7:0]  denom;
			logic [63:0] us;
			first   = expected_bytes.size();
			dropped = 1'b0;
			trk     = ev.channel;
			nib     = {4'h0, 4'(ev.channel - 5'd1)};
			if ((ev.mode <= MODE_PROGRAM || ev.mode == MODE_TRACK_END) &&
			    ev.channel >= TRACK_COUNT)
				dropped = 1'b1;
			else case (ev.mode)
				MODE_NOTE_ON, MODE_NOTE_OFF: begin
					push_delta(trk, ev.tick);
					push_byte(trk, (ev.mode == MODE_NOTE_ON ? ST_NOTE_ON : ST_NOTE_OFF) | nib);
					push_byte(trk, {1'b0, ev.note});
					// force note-off velocity to zero
					push_byte(trk, ev.mode == MODE_NOTE_ON ? {1'b0, ev.velocity} : ZERO_BYTE);
				end
				MODE_PROGRAM: begin
					push_delta(trk, ev.tick);
					push_byte(trk, ST_CTRL | nib);
					push_byte(trk, CC_BANK_MSB);
					push_byte(trk, {1'b0, ev.bank_msb});
					push_delta(trk, ev.tick);
					push_byte(trk, ST_CTRL | nib);
					push_byte(trk, CC_BANK_LSB);
					push_byte(trk, {1'b0, ev.bank_lsb});
					push_delta(trk, ev.tick);
					push_byte(trk, ST_PROGRAM | nib);
					push_byte(trk, {1'b0, ev.program_req});
				end
				MODE_TIME_SIG: begin
					lg    = '0;
					denom = ev.beat_unit;
					while (denom > 8'd1) begin
						denom = denom >> 1;
						lg++;
					end
					push_delta(5'd0, ev.tick);
					push_byte(5'd0, ST_META);
					push_byte(5'd0, META_TSIG);
					push_byte(5'd0, TSIG_LEN);
					push_byte(5'd0, ev.beats);
					push_byte(5'd0, lg);
					push_byte(5'd0, TSIG_CLOCKS);
					push_byte(5'd0, TSIG_32ND);
				end
				MODE_TEMPO: begin
					if (ev.tempo_q8 == '0)
						us = 64'(US_MAX);
					else
						us = 64'(DIV_NUM) / 64'(ev.tempo_q8);
					if (us > 64'(US_MAX)) us = 64'(US_MAX);
					push_delta(5'd0, ev.tick);
					push_byte(5'd0, ST_META);
					push_byte(5'd0, META_TEMPO);
					push_byte(5'd0, TEMPO_LEN);
					push_byte(5'd0, us[23:16]);
					push_byte(5'd0, us[15:8]);
					push_byte(5'd0, us[7:0]);
				end
				MODE_TRACK_END: begin
					if (!has_data[trk])
						dropped = 1'b1;
					else begin
						push_delta(trk, last_tick[trk]);
						push_byte(trk, ST_META);
						push_byte(trk, META_EOT);
						push_byte(trk, EOT_LEN);
					end
				end
				default: dropped = 1'b1;
			endcase
			if (dropped) begin
				events_dropped++;
				return 0;
			end
			expected_bytes[$].last_byte = 1'b1;
			events_noted++;
			return expected_bytes.size() - first;
		endfunction

		function void check_byte(midi_byte_t got);
			midi_byte_t want;
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				if (errors < REPORT_LIMIT)
					$display("%0t: unexpected byte track=%0d byte=%02h last=%0b",
					         $realtime, got.track, got.byte_value, got.last_byte);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			if (want !== got) begin
				if (errors < REPORT_LIMIT)
					$display("%0t: exp trk=%0d byte=%02h last=%0b got trk=%0d byte=%02h last=%0b",
					         $realtime, want.track, want.byte_value, want.last_byte,
					         got.track, got.byte_value, got.last_byte);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata  = '0;
	logic [S_USER_W-1:0] s_axis_tuser  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic [M_USER_W-1:0] m_axis_tuser;
	logic                m_axis_tlast;

	track_byte_scoreboard sb = new();
	int          idle_pct    = 0;
	int          stall_pct   = 0;
	int          holdoff_req = 0;
	int          holdoff_left = 0;
	int          cycles      = 0;
	logic [31:0] song_tick   = '0;

	midi_track_event_serializer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still expected",
			         cycles, sb.expected_bytes.size());
			$display("midi_track_event_serializer_unit_test NOT OK");
			$finish;
		end
	end

	// Check taken bytes, then pick the next tready; a long hold-off is counted here.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_byte(midi_byte_t'({m_axis_tuser, m_axis_tdata, m_axis_tlast}));
		if (holdoff_left == 0 && holdoff_req != 0) begin
			holdoff_left = holdoff_req;
			holdoff_req  = 0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic midi_event_t random_fields(logic [2:0] mode, logic [31:0] tick,
	                                              logic [4:0] ch);
		midi_event_t ev;
		ev.mode        = mode;
		ev.tick        = tick;
		ev.channel     = ch;
		ev.note        = 7'($urandom);
		ev.velocity    = 7'($urandom);
		ev.bank_msb    = 7'($urandom);
		ev.bank_lsb    = 7'($urandom);
		ev.program_req = 7'($urandom);
		ev.beats       = 8'($urandom);
		ev.beat_unit   = ($urandom_range(99) < 60) ? 8'(1 << $urandom_range(7))
		                                           : 8'($urandom);
		case ($urandom_range(9))
			0, 1, 2, 3, 4: ev.tempo_q8 = 24'($urandom_range(300 * 256, 30 * 256));
			5, 6:          ev.tempo_q8 = 24'($urandom_range(1000));
			default:       ev.tempo_q8 = 24'($urandom);
		endcase
		return ev;
	endfunction

	// Mostly well-formed traffic on valid tracks with an advancing song position.
	function automatic midi_event_t next_event();
		int          r;
		logic [2:0]  mode;
		logic [4:0]  ch;
		r = $urandom_range(99);
		if (r < 30)      mode = MODE_NOTE_ON;
		else if (r < 55) mode = MODE_NOTE_OFF;
		else if (r < 65) mode = MODE_PROGRAM;
		else if (r < 73) mode = MODE_TIME_SIG;
		else if (r < 82) mode = MODE_TEMPO;
		else if (r < 93) mode = MODE_TRACK_END;
		else             mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
		ch = ($urandom_range(99) < 90) ? 5'($urandom_range(16)) : 5'($urandom_range(31, 17));
		case ($urandom_range(9))
			0, 1, 2, 3, 4: song_tick = song_tick + $urandom_range(127);
			5, 6:          song_tick = song_tick + $urandom_range(16383, 128);
			7, 8:          song_tick = song_tick + $urandom_range(32'h1FFFFF, 16384);
			default:       song_tick = song_tick + $urandom_range(32'hFFFFFFF, 32'h200000);
		endcase
		return random_fields(mode, ($urandom_range(99) < 8) ? $urandom : song_tick, ch);
	endfunction

	task automatic send_event(input midi_event_t ev, output int nres);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= ev.mode;
		s_axis_tdata  <= {ev.tempo_q8, ev.beat_unit, ev.beats, ev.program_req, ev.bank_lsb,
		                  ev.bank_msb, ev.velocity, ev.note, ev.channel, ev.tick};
		do @(posedge clk); while (!s_axis_tready);
		nres = sb.note_event(ev);
	endtask

	task automatic play(input midi_event_t ev);
		int nres;
		send_event(ev, nres);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_bytes.size() != 0);
	endtask

	initial begin
		midi_event_t ev;
		int          counted;
		int          idle_tbl [4];
		int          stall_tbl [4];
		idle_tbl  = '{0, 74, 0, 37};
		stall_tbl = '{0, 0, 74, 37};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// track end on a track that never held data
		play(random_fields(MODE_TRACK_END, 32'd50, 5'd1));
		// delta lengths of one to four bytes, near the byte-count boundaries
		ev = random_fields(MODE_NOTE_ON, 32'h7F, 5'd1);
		ev.note = 7'h7F; ev.velocity = 7'h7F;
		play(ev);
		ev = random_fields(MODE_NOTE_OFF, 32'hFF, 5'd1);
		ev.note = 7'h00; ev.velocity = 7'h7F;
		play(ev);
		ev = random_fields(MODE_NOTE_ON, 32'h3FFF, 5'd16);
		ev.note = 7'h00; ev.velocity = 7'h00;
		play(ev);
		play(random_fields(MODE_NOTE_ON, 32'h7FFF, 5'd16));
		play(random_fields(MODE_NOTE_OFF, 32'h227FFE, 5'd16));
		play(random_fields(MODE_NOTE_ON, 32'h427FFE, 5'd16));
		play(random_fields(MODE_NOTE_ON, 32'h0FFFFFFF, 5'd2));
		play(random_fields(MODE_NOTE_ON, 32'h80000000, 5'd2));
		play(random_fields(MODE_NOTE_OFF, 32'h7FFFFFFF, 5'd2));
		// channel zero wraps the status nibble
		play(random_fields(MODE_NOTE_ON, 32'd5, 5'd0));
		ev = random_fields(MODE_PROGRAM, 32'd1000, 5'd3);
		ev.bank_msb = 7'h7F; ev.bank_lsb = 7'h00; ev.program_req = 7'h7F;
		play(ev);
		ev = random_fields(MODE_PROGRAM, 32'd1200, 5'd0);
		ev.bank_msb = 7'h00; ev.bank_lsb = 7'h7F; ev.program_req = 7'h00;
		play(ev);
		ev = random_fields(MODE_TIME_SIG, 32'd2000, 5'd9);
		ev.beats = 8'hFF; ev.beat_unit = 8'd0;
		play(ev);
		ev = random_fields(MODE_TIME_SIG, 32'd2000, 5'd0);
		ev.beats = 8'h00; ev.beat_unit = 8'd1;
		play(ev);
		ev = random_fields(MODE_TIME_SIG, 32'hFFFFFFFF, 5'd31);
		ev.beats = 8'd4; ev.beat_unit = 8'hFF;
		play(ev);
		// tempo: zero, around the saturation edge, both ends of the range
		ev = random_fields(MODE_TEMPO, 32'd3000, 5'd0);
		foreach (idle_tbl[i]) begin
			case (i)
				0: ev.tempo_q8 = 24'd0;
				1: ev.tempo_q8 = 24'd915;
				2: ev.tempo_q8 = 24'd916;
				default: ev.tempo_q8 = 24'hFFFFFF;
			endcase
			play(ev);
		end
		ev.tempo_q8 = 24'd30720;
		play(ev);
		// out-of-range tracks and an unused mode are dropped, then track ends on tracks with data
		play(random_fields(MODE_NOTE_ON, 32'd4000, 5'd17));
		play(random_fields(MODE_TRACK_END, 32'd4000, 5'd17));
		play(random_fields(MODE_SPARE_6, 32'd4000, 5'd3));
		play(random_fields(MODE_TRACK_END, 32'd0, 5'd16));
		play(random_fields(MODE_TRACK_END, 32'd0, 5'd0));
		drain();

		song_tick = 32'd5000;
		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_tbl[p];
			stall_pct = stall_tbl[p];
			// back up the output while the sender keeps going
			if (p == 0) holdoff_req = HOLDOFF_LEN;
			counted = 0;
			while (counted < PHASE_EVENTS) begin
				play(next_event());
				counted++;
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d events with bytes and %0d dropped ones; %0d bytes compared.",
		         sb.events_noted, sb.events_dropped, sb.bytes_checked);
		$display("Phases: no idling, input gaps, output stalls, both; one long output hold-off.");
		if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
			$display("midi_track_event_serializer_unit_test OK");
		end else begin
			$display("%0d errors, %0d bytes missing", sb.errors, sb.expected_bytes.size());
			$display("midi_track_event_serializer_unit_test NOT OK");
		end
		$finish;
	end

endmodule
